// File: hdl/sli_pkg.sv
// Shared constants and types for the sorted list insert/remove block.
`default_nettype none
package sli_pkg;
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VAL_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} sli_cmd_t;
endpackage
`default_nettype wire

// File: hdl/sli_ctrl.sv
// Controller state machine: takes a request, runs one update, strobes the result.
`default_nettype none
module sli_ctrl
	import sli_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output sli_cmd_t  cmd
);
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy     = (state_q == S_EXEC);
	assign done     = done_q;
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.exec = (state_q == S_EXEC);
endmodule
`default_nettype wire

// File: hdl/sli_dpath.sv
// Datapath: row of entry cells with parallel compare and shift, result registers.
`default_nettype none
module sli_dpath
	import sli_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sli_cmd_t           cmd,
	input  wire logic               operation,
	input  wire logic signed [31:0] item_value,
	output logic [1:0]              status,
	output logic signed [31:0]      returned_value,
	output logic [4:0]              entry_count
);
	logic signed [VAL_W-1:0] ent_q [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic                    op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [1:0]              status_q;
	logic signed [VAL_W-1:0] ret_q;

	logic [CAPACITY-1:0]     valid;
	logic [CAPACITY-1:0]     lt;
	logic [CAPACITY-1:0]     eq;
	logic [CAPACITY-1:0]     lt_prev;
	logic signed [VAL_W-1:0] ent_prev [CAPACITY];
	logic signed [VAL_W-1:0] ent_next [CAPACITY];
	logic                    full;
	logic                    found;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign valid[gi] = CNT_W'(gi) < count_q;
			assign lt[gi]    = valid[gi] && (ent_q[gi] < val_q);
			assign eq[gi]    = valid[gi] && (ent_q[gi] == val_q);
			if (gi == 0) begin : g_first
				assign lt_prev[gi]  = 1'b1;
				assign ent_prev[gi] = val_q;
			end else begin : g_mid
				assign lt_prev[gi]  = lt[gi-1];
				assign ent_prev[gi] = ent_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign ent_next[gi] = ent_q[gi];
			end else begin : g_up
				assign ent_next[gi] = ent_q[gi+1];
			end

			// insert: cells from the insert point up to count shift toward the tail;
			// remove: cells from the match point shift toward the head
			always_ff @(posedge clk) begin
				if (cmd.exec) begin
					if (op_q == OP_INSERT) begin
						if (!full && CNT_W'(gi) <= count_q && !lt[gi])
							ent_q[gi] <= lt_prev[gi] ? val_q : ent_prev[gi];
					end else begin
						if (found && valid[gi] && !lt[gi])
							ent_q[gi] <= ent_next[gi];
					end
				end
			end
		end
	endgenerate

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = |eq;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			val_q <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_INSERT) begin
				if (!full) count_q <= count_q + 1'b1;
			end else if (found) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_INSERT) begin
				status_q <= full ? STATUS_FULL : STATUS_DONE;
				ret_q    <= '0;
			end else if (found) begin
				status_q <= STATUS_DONE;
				ret_q    <= val_q;
			end else begin
				status_q <= STATUS_NOT_FOUND;
				ret_q    <= '0;
			end
		end
	end

	assign status         = status_q;
	assign returned_value = ret_q;
	assign entry_count    = 5'(count_q);
endmodule
`default_nettype wire

// File: hdl/sorted_list_insert_remove.sv
// Sorted list of signed 32-bit values: in-order insert and first-match remove.
// A request is taken when start is high and busy is low; busy then stays high for
// one cycle while every cell compares against the value and shifts in parallel,
// and the result appears on the next cycle for exactly one cycle with done high.
// A request passes through the request capture and then the single compare-and-shift
// step. The receiver cannot stall: a result not taken while done is high is gone.
// No clearing pass after reset; the list starts empty.
`default_nettype none
module sorted_list_insert_remove
	import sli_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic signed [31:0] item_value,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      returned_value,
	output logic [4:0]              entry_count
);
	sli_cmd_t cmd;

	sli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sli_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operation      (operation),
		.item_value     (item_value),
		.status         (status),
		.returned_value (returned_value),
		.entry_count    (entry_count)
	);
endmodule
`default_nettype wire

// File: dv/sli_checker.sv
// Checker for the sorted list block: models the list, matches each result against it.
`default_nettype none
module sli_checker
	import sli_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic               operation,
	input  wire logic signed [31:0] item_value,
	input  wire logic               done,
	input  wire logic [1:0]         status,
	input  wire logic signed [31:0] returned_value,
	input  wire logic [4:0]         entry_count,
	output int                      fail_count,
	output int                      replies_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [4:0]         count;
	} list_reply_t;

	logic signed [31:0] model_cells [CAPACITY];
	int                 model_held = 0;
	list_reply_t        owed_replies [$];

	initial fail_count = 0;

	function automatic list_reply_t apply_list_op(input logic op,
			input logic signed [31:0] v);
		list_reply_t r;
		int pos;
		r.status = STATUS_DONE;
		r.value  = '0;
		pos = 0;
		if (op == OP_INSERT) begin
			if (model_held >= CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				// new value goes ahead of equal ones
				while (pos < model_held && v > model_cells[pos])
					pos++;
				for (int i = model_held; i > pos; i--)
					model_cells[i] = model_cells[i - 1];
				model_cells[pos] = v;
				model_held++;
			end
		end else begin
			while (pos < model_held && model_cells[pos] != v)
				pos++;
			if (pos < model_held) begin
				for (int i = pos; i + 1 < model_held; i++)
					model_cells[i] = model_cells[i + 1];
				model_held--;
				r.value = v;
			end else begin
				r.status = STATUS_NOT_FOUND;
			end
		end
		r.count = 5'(model_held);
		return r;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		if (!arst_n) begin
			model_held = 0;
			owed_replies.delete();
		end else begin
			if (done) begin
				if (owed_replies.size() == 0) begin
					note_failure($sformatf("unexpected result: status %0d value %0d count %0d",
						status, returned_value, entry_count));
				end else begin
					want = owed_replies.pop_front();
					if (status !== want.status || returned_value !== want.value ||
							entry_count !== want.count)
						note_failure($sformatf(
							"mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
							want.status, want.value, want.count,
							status, returned_value, entry_count));
				end
			end
			if (start && !busy)
				owed_replies.push_back(apply_list_op(operation, item_value));
		end
		replies_owed = owed_replies.size();
	end
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Testbench top for the sorted list block: clock, reset, request stimulus, verdict.
`default_nettype none
module tb_top
	import sli_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1750;
	localparam int CYCLE_LIMIT     = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               operation = OP_INSERT;
	logic signed [31:0] item_value = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] returned_value;
	logic [4:0]         entry_count;
	int                 fail_count;
	int                 replies_owed;
	int                 cycles = 0;
	bit                 allow_gaps = 1'b1;
	logic signed [31:0] live_values [$];

	always #6 clk = ~clk;

	sorted_list_insert_remove DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.item_value(item_value),
		.done(done),
		.status(status),
		.returned_value(returned_value),
		.entry_count(entry_count)
	);

	sli_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.item_value(item_value),
		.done(done),
		.status(status),
		.returned_value(returned_value),
		.entry_count(entry_count),
		.fail_count(fail_count),
		.replies_owed(replies_owed)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge that takes the request
	task automatic issue_request(input logic op, input logic signed [31:0] v);
		if (allow_gaps && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		item_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == OP_INSERT) begin
			live_values.push_back(v);
			if (live_values.size() > 32)
				void'(live_values.pop_front());
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: pick_value = 32'($urandom_range(0, 16)) - 32'sd8;
			4: case ($urandom_range(0, 5))
				0: pick_value = 32'h8000_0000;
				1: pick_value = 32'h7fff_ffff;
				2: pick_value = 32'h8000_0001;
				3: pick_value = 32'h7fff_fffe;
				4: pick_value = '0;
				default: pick_value = -32'sd1;
			endcase
			default: pick_value = $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_remove_key();
		int idx;
		logic signed [31:0] k;
		if (live_values.size() > 0 && $urandom_range(0, 99) < 70) begin
			idx = $urandom_range(0, live_values.size() - 1);
			k = live_values[idx];
			live_values.delete(idx);
		end else begin
			k = pick_value();
		end
		return k;
	endfunction

	initial begin
		int insert_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty remove, extremes, duplicates, key zero, full list
		issue_request(OP_REMOVE, 32'sd0);
		issue_request(OP_INSERT, 32'h7fff_ffff);
		issue_request(OP_INSERT, 32'h8000_0000);
		issue_request(OP_INSERT, 32'sd0);
		issue_request(OP_INSERT, 32'sd0);
		issue_request(OP_INSERT, -32'sd1);
		issue_request(OP_REMOVE, 32'sd0);
		issue_request(OP_REMOVE, 32'sd5);
		issue_request(OP_REMOVE, 32'h8000_0000);
		repeat (CAPACITY - 3)
			issue_request(OP_INSERT, $urandom);
		issue_request(OP_INSERT, 32'sd42);
		issue_request(OP_REMOVE, 32'h7fff_ffff);
		issue_request(OP_REMOVE, -32'sd1);

		// random: alternate fill-heavy and drain-heavy stretches to hit full and empty
		live_values.delete();
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			allow_gaps = !(n >= 700 && n < 1000);
			insert_pct = ((n / 120) % 2 == 0) ? 72 : 28;
			if ($urandom_range(0, 99) < insert_pct)
				issue_request(OP_INSERT, pick_value());
			else
				issue_request(OP_REMOVE, pick_remove_key());
		end
		start <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
